[design/block_log_record_framer_defines.svh]
// Assertion macros shared by the log record framer RTL.
`ifndef BLOCK_LOG_RECORD_FRAMER_DEFINES_SVH
`define BLOCK_LOG_RECORD_FRAMER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define BLRF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer check failed");

// Next-cycle implication.
`define BLRF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer check failed");

`endif

[design/blrf_pkg.sv]
// Shared constants, codes and types of the log record block framer.
`timescale 1ns / 1ps
`default_nettype none

package blrf_pkg;

    localparam int BLOCK_SIZE  = 32768;
    localparam int HEADER_SIZE = 4;
    localparam int POS_W       = 16;
    localparam int ROOM_W      = POS_W + 1;
    localparam int AMOUNT_W    = 32;
    localparam int IN_DATA_W   = 40;
    localparam int MAX_RESULTS = 8;
    localparam int IDX_W       = 3;
    localparam int CNT_W       = 4;
    localparam int PAD_W       = 3;

    typedef enum logic [1:0] {
        OP_START  = 2'd0,
        OP_BYTE   = 2'd1,
        OP_BLANK  = 2'd2,
        OP_SETPOS = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BLANK_SHORT = 2'd1,
        ST_NO_RECORD   = 2'd2,
        ST_START_OPEN  = 2'd3
    } status_t;

    typedef enum logic [7:0] {
        REC_EMPTY  = 8'd0,
        REC_FULL   = 8'd1,
        REC_FIRST  = 8'd2,
        REC_MIDDLE = 8'd3,
        REC_LAST   = 8'd4
    } rec_type_t;

    typedef struct packed {
        logic [POS_W-1:0]    pos;
        logic [AMOUNT_W-1:0] rbl;
        logic                first;
        logic                blank;
    } frag_req_t;

    typedef struct packed {
        logic [PAD_W-1:0]    pad_count;
        logic [POS_W-1:0]    pos;
        logic [AMOUNT_W-1:0] rbl;
        logic [POS_W-1:0]    frag;
        rec_type_t           rec_type;
        logic                close;
    } frag_plan_t;

endpackage

`default_nettype wire

[design/blrf_frag.sv]
// Fragment planner: tail padding, fragment length and header type.
`timescale 1ns / 1ps
`default_nettype none

module blrf_frag (
    input  blrf_pkg::frag_req_t  req,
    output blrf_pkg::frag_plan_t plan
);
    import blrf_pkg::*;

    logic [ROOM_W-1:0]   room;
    logic                short_tail;
    logic [POS_W-1:0]    pos0;
    logic [ROOM_W-1:0]   avail;
    logic [AMOUNT_W-1:0] frag_w;
    logic                at_end;

    always_comb
    begin
        room       = ROOM_W'(BLOCK_SIZE) - {1'b0, req.pos};
        short_tail = room <= ROOM_W'(HEADER_SIZE);
        pos0       = short_tail ? '0 : req.pos;
        avail      = ROOM_W'(BLOCK_SIZE) - {1'b0, pos0} - ROOM_W'(HEADER_SIZE);
        frag_w     = (req.rbl < AMOUNT_W'(avail)) ? req.rbl : AMOUNT_W'(avail);
        at_end     = frag_w == req.rbl;

        plan.pad_count = short_tail ? PAD_W'(room) : '0;
        // room > header here, so the header never reaches the block end
        plan.pos   = pos0 + POS_W'(HEADER_SIZE);
        plan.rbl   = req.rbl - frag_w;
        plan.frag  = POS_W'(frag_w);
        plan.close = frag_w == '0;
        if (req.blank)
            plan.rec_type = REC_EMPTY;
        else if (req.first)
            plan.rec_type = at_end ? REC_FULL : REC_FIRST;
        else
            plan.rec_type = at_end ? REC_LAST : REC_MIDDLE;
    end

endmodule

`default_nettype wire

[design/block_log_record_framer.sv]
// Log record block framer top level.
// Path: each input passes the input register, then the result burst register, before its first result.
// Throughput: one item per cycle while each item yields one result and m_tready is high; an item that
// yields n results (header, tail padding) holds the result serializer until all n are sent.
// Reset: rst_n clears block offset, record state and both valid flags at once.
`timescale 1ns / 1ps
`default_nettype none
`include "block_log_record_framer_defines.svh"

module block_log_record_framer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [blrf_pkg::IN_DATA_W-1:0]   s_tdata,  // amount[31:0], data_byte[39:32]
    input  logic [1:0]                       s_tuser,  // opcode[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,  // out_byte[7:0]
    output logic [2:0]                       m_tuser,  // byte_valid[0], status[2:1]
    output logic                             m_tlast
);
    import blrf_pkg::*;

    // input register
    logic                in_valid_reg;
    opcode_t             in_op_reg;
    logic [AMOUNT_W-1:0] in_amount_reg;
    logic [7:0]          in_byte_reg;

    // framing state
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [AMOUNT_W-1:0] rbl_reg, rbl_next;
    logic [POS_W-1:0]    fbl_reg, fbl_next;
    logic                open_reg, open_next;
    logic                blank_reg, blank_next;

    // result burst register
    logic                desc_valid_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    cnt_reg;
    status_t             status_reg;
    logic                bvalid_reg;
    logic [7:0]          bytes_reg [MAX_RESULTS];

    logic                out_fire;
    logic                desc_last;
    logic                desc_free;
    logic                consume;
    logic                gen_load;

    logic [ROOM_W-1:0]   pos_plus;
    logic [POS_W-1:0]    pos_inc;
    logic [POS_W-1:0]    fbl_dec;
    frag_req_t           req;
    frag_plan_t          plan;

    logic                has_byte;
    logic                has_hdr;
    logic [7:0]          first_byte;
    logic [PAD_W-1:0]    pad;
    logic [CNT_W-1:0]    gen_cnt;
    status_t             gen_status;
    logic                gen_bvalid;
    logic [7:0]          gen_bytes [MAX_RESULTS];
    logic [23:0]         frag_len;
    logic [7:0]          hdr [HEADER_SIZE];
    logic [CNT_W-1:0]    hofs;

    blrf_frag u_frag (
        .req  (req),
        .plan (plan)
    );

    assign out_fire  = m_tvalid && m_tready;
    assign desc_last = ({1'b0, idx_reg} + CNT_W'(1)) == cnt_reg;
    assign desc_free = !desc_valid_reg || (out_fire && desc_last);
    assign consume   = in_valid_reg && (desc_free || in_op_reg == OP_SETPOS);
    assign gen_load  = consume && in_op_reg != OP_SETPOS;
    assign s_tready  = !in_valid_reg || consume;

    assign m_tvalid = desc_valid_reg;
    assign m_tdata  = bytes_reg[idx_reg];
    assign m_tuser  = {status_reg, bvalid_reg};
    assign m_tlast  = desc_last;

    always_comb
    begin
        pos_plus = {1'b0, pos_reg} + ROOM_W'(1);
        pos_inc  = (pos_plus >= ROOM_W'(BLOCK_SIZE)) ? '0 : POS_W'(pos_plus);
        fbl_dec  = (fbl_reg != '0) ? fbl_reg - POS_W'(1) : '0;

        req.pos   = (in_op_reg == OP_BYTE) ? pos_inc : pos_reg;
        req.first = in_op_reg != OP_BYTE;
        req.blank = (in_op_reg == OP_BYTE) ? blank_reg : (in_op_reg == OP_BLANK);
        case (in_op_reg)
            OP_START: req.rbl = in_amount_reg;
            OP_BLANK: req.rbl = in_amount_reg - AMOUNT_W'(HEADER_SIZE);
            default:  req.rbl = rbl_reg;
        endcase
    end

    always_comb
    begin
        pos_next   = pos_reg;
        rbl_next   = rbl_reg;
        fbl_next   = fbl_reg;
        open_next  = open_reg;
        blank_next = blank_reg;
        has_byte   = 1'b0;
        has_hdr    = 1'b0;
        first_byte = '0;
        gen_status = ST_OK;
        gen_bvalid = 1'b1;

        case (in_op_reg)
            OP_START, OP_BLANK:
            begin
                if (open_reg)
                begin
                    gen_status = ST_START_OPEN;
                    gen_bvalid = 1'b0;
                end
                else if (in_op_reg == OP_BLANK && in_amount_reg < AMOUNT_W'(HEADER_SIZE))
                begin
                    gen_status = ST_BLANK_SHORT;
                    gen_bvalid = 1'b0;
                end
                else
                begin
                    has_hdr    = 1'b1;
                    open_next  = 1'b1;
                    blank_next = in_op_reg == OP_BLANK;
                end
            end
            OP_BYTE:
            begin
                if (!open_reg)
                begin
                    gen_status = ST_NO_RECORD;
                    gen_bvalid = 1'b0;
                end
                else
                begin
                    has_byte   = 1'b1;
                    first_byte = blank_reg ? 8'h00 : in_byte_reg;
                    pos_next   = pos_inc;
                    fbl_next   = fbl_dec;
                    if (fbl_dec == '0)
                    begin
                        if (rbl_reg == '0)
                        begin
                            open_next  = 1'b0;
                            blank_next = 1'b0;
                        end
                        else
                        begin
                            has_hdr = 1'b1;
                        end
                    end
                end
            end
            OP_SETPOS:
            begin
                pos_next   = POS_W'(in_amount_reg % BLOCK_SIZE);
                rbl_next   = '0;
                fbl_next   = '0;
                open_next  = 1'b0;
                blank_next = 1'b0;
            end
            default:
            begin
                gen_bvalid = 1'b0;
            end
        endcase

        if (has_hdr)
        begin
            pos_next = plan.pos;
            rbl_next = plan.rbl;
            fbl_next = plan.frag;
            if (plan.close)
            begin
                open_next  = 1'b0;
                blank_next = 1'b0;
                rbl_next   = '0;
                fbl_next   = '0;
            end
        end
    end

    // burst contents: optional payload byte, then, when a header is due, zero padding and the header
    always_comb
    begin
        frag_len = 24'(plan.frag);
        hdr[0]   = frag_len[7:0];
        hdr[1]   = frag_len[15:8];
        hdr[2]   = frag_len[23:16];
        hdr[3]   = plan.rec_type;
        pad      = has_hdr ? plan.pad_count : '0;
        hofs     = '0;
        if (!gen_bvalid)
            gen_cnt = CNT_W'(1);
        else
            gen_cnt = CNT_W'(has_byte)
                    + (has_hdr ? CNT_W'(pad) + CNT_W'(HEADER_SIZE) : '0);
        for (int j = 0; j < MAX_RESULTS; j++)
        begin
            hofs = CNT_W'(j) - CNT_W'(has_byte) - CNT_W'(pad);
            if (has_byte && j == 0)
                gen_bytes[j] = first_byte;
            else if (has_hdr && hofs < CNT_W'(HEADER_SIZE))
                gen_bytes[j] = hdr[hofs[1:0]];
            else
                gen_bytes[j] = 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            pos_reg        <= '0;
            rbl_reg        <= '0;
            fbl_reg        <= '0;
            open_reg       <= 1'b0;
            blank_reg      <= 1'b0;
            desc_valid_reg <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (consume)
                in_valid_reg <= 1'b0;

            if (consume)
            begin
                pos_reg   <= pos_next;
                rbl_reg   <= rbl_next;
                fbl_reg   <= fbl_next;
                open_reg  <= open_next;
                blank_reg <= blank_next;
            end

            if (gen_load)
            begin
                desc_valid_reg <= 1'b1;
                idx_reg        <= '0;
            end
            else if (out_fire && desc_last)
            begin
                desc_valid_reg <= 1'b0;
            end
            else if (out_fire)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_op_reg     <= opcode_t'(s_tuser);
            in_amount_reg <= s_tdata[AMOUNT_W-1:0];
            in_byte_reg   <= s_tdata[IN_DATA_W-1:AMOUNT_W];
        end
        if (gen_load)
        begin
            cnt_reg    <= gen_cnt;
            status_reg <= gen_status;
            bvalid_reg <= gen_bvalid;
            bytes_reg  <= gen_bytes;
        end
    end

    `BLRF_ASSERT_NOW(a_pos_in_block, 1'b1, pos_reg < POS_W'(BLOCK_SIZE))
    `BLRF_ASSERT_NOW(a_open_has_frag, open_reg, fbl_reg != '0)
    `BLRF_ASSERT_NOW(a_closed_is_clear, !open_reg,
        rbl_reg == '0 && fbl_reg == '0 && !blank_reg)
    `BLRF_ASSERT_NOW(a_idx_in_burst, desc_valid_reg, {1'b0, idx_reg} < cnt_reg)
    `BLRF_ASSERT_NEXT(a_burst_advance, out_fire && !desc_last && !gen_load,
        desc_valid_reg && idx_reg == $past(idx_reg) + IDX_W'(1))

endmodule

`default_nettype wire
